[sv/lht_pkg.sv]
`timescale 1ns / 1ps

package lht_pkg;

    // table geometry
    localparam int MAX_BUCKETS  = 64;
    localparam int BUCKET_SLOTS = 64;
    localparam int BKT_W        = $clog2(MAX_BUCKETS);
    localparam int SLOT_W       = $clog2(BUCKET_SLOTS);
    localparam int CNT_W        = SLOT_W + 1;
    localparam int LVL_W        = BKT_W + 1;
    localparam int ENTRY_DEPTH  = MAX_BUCKETS * BUCKET_SLOTS;
    localparam int KEY_W        = 31;
    localparam int VAL_W        = 32;
    localparam int CFG_W        = 6;

    // configuration register indexes
    localparam logic [1:0] CFG_BUCKET_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_INITIAL_BUCKETS = 2'd1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_MATCH    = 2'd2;
    localparam logic [1:0] ST_MISS     = 2'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_LOC,
        S_CNT,
        S_SRCH,
        S_SPL0,
        S_SPL1,
        S_SPLR,
        S_SPL2,
        S_SPLW,
        S_SEND1,
        S_SEND2,
        S_FIN
    } lht_state_t;

endpackage

[sv/linear_hash_table_unit.sv]
`timescale 1ns / 1ps

// Linear-hashing key/value table.
// Input channel s_*: mode 0 inserts (s_key, s_item_value), mode 1 searches s_key.
// Result channel m_*: an insert gives one item (inserted or dropped, with
// m_split_done when it split a bucket); a search gives one match item per
// value stored under s_key, in storage order, or one miss item; m_last marks the final one.
// Config channel cfg_*: index 0 bucket_limit, index 1 initial_buckets (clears
// the table); always ready. Write it only while the block is idle; the block itself does not enforce it.
// Bucket lookup uses a shared bit-serial modulo unit; a search then scans the
// slots of the bucket. A split redistributes the split bucket through the
// same modulo unit one entry at a time.
// One item is worked on at a time; s_ready is high only while idle. A finished
// result waits in the output register while the next item is accepted; a
// stalled receiver holds the search scan until it takes the pending item.
// Reset (aresetn low, synchronous) restores bucket_limit 48, two buckets and
// an empty table at once; no clearing pass is needed.
module linear_hash_table_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_mode,
    input  logic [lht_pkg::KEY_W-1:0] s_key,
    input  logic signed [lht_pkg::VAL_W-1:0] s_item_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic signed [lht_pkg::VAL_W-1:0] m_found_value,
    output logic                      m_split_done,
    output logic                      m_last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [lht_pkg::CFG_W-1:0] cfg_data
);
    import lht_pkg::*;

    localparam int ADDR_W = BKT_W + SLOT_W;

    lht_state_t state_reg, state_next;

    // configuration and table control
    logic [CFG_W-1:0] limit_reg;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [LVL_W-1:0] inuse_reg, inuse_next;
    logic [BKT_W-1:0] sp_reg, sp_next;
    logic [MAX_BUCKETS-1:0] cvld_reg;

    // item registers
    logic             mode_reg;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [4:0]       bit_reg, bit_next;
    logic [LVL_W:0]   rem_reg, rem_next;
    logic             splph_reg, splph_next;
    logic [BKT_W-1:0] bkt_reg, bkt_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] scnt_reg, scnt_next, dcnt_reg, dcnt_next;
    logic [1:0]       st_reg, st_next;
    logic             spl_reg, spl_next;
    logic [VAL_W-1:0] pend_reg, pend_next;
    logic             pvld_reg, pvld_next;

    // output register
    logic             ovld_reg, ovld_next;
    logic [1:0]       ost_reg, ost_next;
    logic [VAL_W-1:0] oval_reg, oval_next;
    logic             ospl_reg, ospl_next;
    logic             olast_reg, olast_next;

    // memories
    logic [KEY_W+VAL_W-1:0] entry_mem [ENTRY_DEPTH];
    logic [KEY_W+VAL_W-1:0] ent_rd_reg;
    logic [CNT_W-1:0]       cnt_mem [MAX_BUCKETS];
    logic [CNT_W-1:0]       cnt_rd_reg;
    logic                   vld_rd_reg;

    logic                   ent_we, cnt_we;
    logic [ADDR_W-1:0]      ent_waddr, ent_raddr;
    logic [KEY_W+VAL_W-1:0] ent_wdata;
    logic [BKT_W-1:0]       cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]       cnt_wdata;
    logic                   clr;

    // datapath helpers
    logic [LVL_W:0]   div_d, rem_sh, r1, b8;
    logic [BKT_W-1:0] bkt_loc, tgt;
    logic [CNT_W-1:0] cur_cnt, tcnt;
    logic [LVL_W:0]   dst_w;
    logic             out_free, hit, can_go;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign clr       = cfg_valid && (cfg_index == CFG_INITIAL_BUCKETS);

    assign m_valid       = ovld_reg;
    assign m_status      = ost_reg;
    assign m_found_value = oval_reg;
    assign m_split_done  = ospl_reg;
    assign m_last        = olast_reg;

    assign out_free = !ovld_reg || m_ready;
    assign div_d    = {level_reg, 1'b0};
    assign rem_sh   = {rem_reg[LVL_W-1:0], key_reg[bit_reg]};
    assign rd_key   = ent_rd_reg[KEY_W+VAL_W-1:VAL_W];
    assign rd_val   = ent_rd_reg[VAL_W-1:0];
    assign cur_cnt  = vld_rd_reg ? cnt_rd_reg : '0;
    assign hit      = (rd_key == key_reg);
    assign can_go   = !hit || !pvld_reg || out_free;
    assign dst_w    = {1'b0, {1'b0, sp_reg} + level_reg};

    // bucket from key mod 2L: fold to mod L, keep mod 2L below split pointer
    always_comb begin
        r1 = (rem_reg >= {1'b0, level_reg}) ? rem_reg - {1'b0, level_reg} : rem_reg;
        b8 = (r1 < {2'b0, sp_reg}) ? rem_reg : r1;
        bkt_loc = (b8 >= (LVL_W+1)'(MAX_BUCKETS)) ? BKT_W'(MAX_BUCKETS - 1) : b8[BKT_W-1:0];
        tgt  = (rem_reg == {2'b0, sp_reg}) ? sp_reg : dst_w[BKT_W-1:0];
        tcnt = (rem_reg == {2'b0, sp_reg}) ? scnt_reg : dcnt_reg;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        level_next = level_reg;
        inuse_next = inuse_reg;
        sp_next    = sp_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        splph_next = splph_reg;
        bkt_next   = bkt_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        scnt_next  = scnt_reg;
        dcnt_next  = dcnt_reg;
        st_next    = st_reg;
        spl_next   = spl_reg;
        pend_next  = pend_reg;
        pvld_next  = pvld_reg;
        ovld_next  = ovld_reg && !m_ready;
        ost_next   = ost_reg;
        oval_next  = oval_reg;
        ospl_next  = ospl_reg;
        olast_next = olast_reg;
        ent_we     = 1'b0;
        ent_waddr  = {bkt_reg, idx_reg};
        ent_wdata  = {key_reg, val_reg};
        ent_raddr  = {bkt_reg, idx_reg};
        cnt_we     = 1'b0;
        cnt_waddr  = bkt_reg;
        cnt_wdata  = '0;
        cnt_raddr  = bkt_loc;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    key_next   = s_key;
                    val_next   = s_item_value;
                    bit_next   = 5'(KEY_W - 1);
                    rem_next   = '0;
                    splph_next = 1'b0;
                    spl_next   = 1'b0;
                    pvld_next  = 1'b0;
                    state_next = S_DIV;
                end
            end
            // one restoring step of key mod 2L per cycle
            S_DIV: begin
                rem_next = (rem_sh >= div_d) ? rem_sh - div_d : rem_sh;
                bit_next = bit_reg - 5'd1;
                if (bit_reg == '0) begin
                    state_next = splph_reg ? S_SPLW : S_LOC;
                end
            end
            S_LOC: begin
                bkt_next   = bkt_loc;
                idx_next   = '0;
                state_next = S_CNT;
            end
            S_CNT: begin
                ent_raddr = {bkt_reg, {SLOT_W{1'b0}}};
                n_next    = cur_cnt;
                if (mode_reg == MODE_INSERT) begin
                    if (cur_cnt == CNT_W'(BUCKET_SLOTS)) begin
                        st_next    = ST_DROPPED;
                        state_next = S_FIN;
                    end else begin
                        ent_we     = 1'b1;
                        ent_waddr  = {bkt_reg, cur_cnt[SLOT_W-1:0]};
                        cnt_we     = 1'b1;
                        cnt_wdata  = cur_cnt + CNT_W'(1);
                        st_next    = ST_INSERTED;
                        if ((cur_cnt + CNT_W'(1)) > {1'b0, limit_reg} &&
                            inuse_reg < LVL_W'(MAX_BUCKETS) &&
                            dst_w < (LVL_W+1)'(MAX_BUCKETS)) begin
                            state_next = S_SPL0;
                        end else begin
                            state_next = S_FIN;
                        end
                    end
                end else if (cur_cnt == '0) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_SRCH;
                end
            end
            // one slot per cycle unless a hit waits on the output; read of the next slot issued as this one retires
            S_SRCH: begin
                ent_raddr = can_go ? {bkt_reg, idx_reg + SLOT_W'(1)} : {bkt_reg, idx_reg};
                if (can_go) begin
                    if (hit) begin
                        if (pvld_reg) begin
                            ovld_next  = 1'b1;
                            ost_next   = ST_MATCH;
                            oval_next  = pend_reg;
                            ospl_next  = 1'b0;
                            olast_next = 1'b0;
                        end
                        pend_next = rd_val;
                        pvld_next = 1'b1;
                    end
                    idx_next = idx_reg + SLOT_W'(1);
                    if ({1'b0, idx_reg} == n_reg - CNT_W'(1)) begin
                        state_next = S_FIN;
                    end
                end
            end
            // split: fetch count of the bucket at the split pointer
            S_SPL0: begin
                cnt_raddr  = sp_reg;
                state_next = S_SPL1;
            end
            S_SPL1: begin
                n_next    = cur_cnt;
                idx_next  = '0;
                scnt_next = '0;
                dcnt_next = '0;
                bkt_next  = sp_reg;
                state_next = (cur_cnt == '0) ? S_SEND1 : S_SPLR;
            end
            S_SPLR: begin
                state_next = S_SPL2;
            end
            S_SPL2: begin
                key_next   = rd_key;
                val_next   = rd_val;
                bit_next   = 5'(KEY_W - 1);
                rem_next   = '0;
                splph_next = 1'b1;
                state_next = S_DIV;
            end
            // append the entry to the kept or the new bucket, in order
            S_SPLW: begin
                ent_we    = 1'b1;
                ent_waddr = {tgt, tcnt[SLOT_W-1:0]};
                if (tgt == sp_reg) begin
                    scnt_next = scnt_reg + CNT_W'(1);
                end else begin
                    dcnt_next = dcnt_reg + CNT_W'(1);
                end
                idx_next = idx_reg + SLOT_W'(1);
                if ({1'b0, idx_reg} == n_reg - CNT_W'(1)) begin
                    state_next = S_SEND1;
                end else begin
                    state_next = S_SPLR;
                end
            end
            S_SEND1: begin
                cnt_we     = 1'b1;
                cnt_waddr  = sp_reg;
                cnt_wdata  = scnt_reg;
                state_next = S_SEND2;
            end
            S_SEND2: begin
                cnt_we     = 1'b1;
                cnt_waddr  = dst_w[BKT_W-1:0];
                cnt_wdata  = dcnt_reg;
                inuse_next = inuse_reg + LVL_W'(1);
                spl_next   = 1'b1;
                if ({1'b0, sp_reg} + LVL_W'(1) == level_reg) begin
                    sp_next    = '0;
                    level_next = {level_reg[LVL_W-2:0], 1'b0};
                end else begin
                    sp_next = sp_reg + BKT_W'(1);
                end
                state_next = S_FIN;
            end
            // final result item
            S_FIN: begin
                if (out_free) begin
                    ovld_next  = 1'b1;
                    olast_next = 1'b1;
                    if (mode_reg == MODE_INSERT) begin
                        ost_next  = st_reg;
                        oval_next = '0;
                        ospl_next = spl_reg;
                    end else begin
                        ost_next  = pvld_reg ? ST_MATCH : ST_MISS;
                        oval_next = pvld_reg ? pend_reg : '0;
                        ospl_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // clearing the table on an initial_buckets write
        if (clr) begin
            sp_next    = '0;
            level_next = (cfg_data == '0) ? LVL_W'(1) : LVL_W'(cfg_data);
            inuse_next = (cfg_data == '0) ? LVL_W'(1) : LVL_W'(cfg_data);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            limit_reg <= CFG_W'(48);
            level_reg <= LVL_W'(2);
            inuse_reg <= LVL_W'(2);
            sp_reg    <= '0;
            cvld_reg  <= '0;
            ovld_reg  <= 1'b0;
            mode_reg  <= MODE_INSERT;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
            inuse_reg <= inuse_next;
            sp_reg    <= sp_next;
            ovld_reg  <= ovld_next;
            if (state_reg == S_IDLE && s_valid) begin
                mode_reg <= s_mode;
            end
            if (cfg_valid && cfg_index == CFG_BUCKET_LIMIT) begin
                limit_reg <= cfg_data;
            end
            if (clr) begin
                cvld_reg <= '0;
            end else if (cnt_we) begin
                cvld_reg[cnt_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        val_reg   <= val_next;
        bit_reg   <= bit_next;
        rem_reg   <= rem_next;
        splph_reg <= splph_next;
        bkt_reg   <= bkt_next;
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        scnt_reg  <= scnt_next;
        dcnt_reg  <= dcnt_next;
        st_reg    <= st_next;
        spl_reg   <= spl_next;
        pend_reg  <= pend_next;
        pvld_reg  <= pvld_next;
        ost_reg   <= ost_next;
        oval_reg  <= oval_next;
        ospl_reg  <= ospl_next;
        olast_reg <= olast_next;
    end

    // entry store
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        ent_rd_reg <= entry_mem[ent_raddr];
    end

    // bucket count store
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_raddr];
        vld_rd_reg <= cvld_reg[cnt_raddr];
    end

endmodule
